[rtl/latency_hysteresis_congestion_ctl_top_assert.svh]
// Assertion macros for the latency hysteresis congestion controller.
`ifndef LATENCY_HYSTERESIS_CONGESTION_CTL_TOP_ASSERT_SVH
`define LATENCY_HYSTERESIS_CONGESTION_CTL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define LHCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lhcc assertion failed");
// checked at every edge, reset included
`define LHCC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("lhcc assertion failed");
`else
`define LHCC_ASSERT(label, prop)
`define LHCC_ASSERT_ALWAYS(label, prop)
`endif

`endif

[rtl/lhcc_pkg.sv]
// Package: level codes, thresholds, register indexes and helpers.
`default_nettype none
package lhcc_pkg;

  typedef logic [2:0] lvl_t;

  localparam lvl_t LVL_NORMAL   = 3'd0;
  localparam lvl_t LVL_COMPRESS = 3'd1;
  localparam lvl_t LVL_DELTA    = 3'd2;
  localparam lvl_t LVL_INCR     = 3'd3;
  localparam lvl_t LVL_DROP     = 3'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SAVING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REDIRECT_EN   = 2'd3;

  localparam logic [31:0] NS_PER_BYTE_RST   = 32'd20000;
  localparam logic [23:0] QUEUE_CAP_RST     = 24'd500000;
  localparam logic [7:0]  HEADER_SAVING_RST = 8'd22;

  // rise above / fall below, in ns
  localparam logic [39:0] TH_COMP_UP = 40'd15000000;
  localparam logic [39:0] TH_COMP_DN = 40'd10000000;
  localparam logic [39:0] TH_DELT_UP = 40'd30000000;
  localparam logic [39:0] TH_DELT_DN = 40'd20000000;
  localparam logic [39:0] TH_INCR_UP = 40'd60000000;
  localparam logic [39:0] TH_INCR_DN = 40'd40000000;
  localparam logic [39:0] TH_DROP_UP = 40'd100000000;
  localparam logic [39:0] TH_DROP_DN = 40'd80000000;

  localparam logic [7:0] TOS_COMPRESS = 8'h28;
  localparam logic [7:0] TOS_DELTA    = 8'h50;
  localparam logic [7:0] TOS_INCR     = 8'h64;
  localparam logic [7:0] TOS_DROP     = 8'h78;

  // ceil(2^18 / 5): exact x/5 for any 17-bit x after >> 18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  function automatic lvl_t next_level(input lvl_t cur, input logic [39:0] lat);
    lvl_t nxt;
    nxt = cur;
    case (cur)
      LVL_NORMAL: begin
        if (lat > TH_COMP_UP) nxt = LVL_COMPRESS;
      end
      LVL_COMPRESS: begin
        if (lat > TH_DELT_UP) nxt = LVL_DELTA;
        else if (lat < TH_COMP_DN) nxt = LVL_NORMAL;
      end
      LVL_DELTA: begin
        if (lat > TH_INCR_UP) nxt = LVL_INCR;
        else if (lat < TH_DELT_DN) nxt = LVL_COMPRESS;
      end
      LVL_INCR: begin
        if (lat > TH_DROP_UP) nxt = LVL_DROP;
        else if (lat < TH_INCR_DN) nxt = LVL_DELTA;
      end
      default: begin
        if (lat < TH_DROP_DN) nxt = LVL_INCR;
        else nxt = LVL_DROP;
      end
    endcase
    return nxt;
  endfunction

  function automatic logic [7:0] tos_of(input lvl_t lvl);
    logic [7:0] t;
    case (lvl)
      LVL_COMPRESS: t = TOS_COMPRESS;
      LVL_DELTA:    t = TOS_DELTA;
      LVL_INCR:     t = TOS_INCR;
      LVL_DROP:     t = TOS_DROP;
      default:      t = 8'h00;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/latency_hysteresis_congestion_ctl_top.sv]
// Latency hysteresis congestion controller, top level.
//
// One input transaction per target packet (sojourn, time, length, peer level,
// IPv6 flag, old TOS) on a valid/ready channel; one result transaction per
// packet on a valid/ready output channel. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user is to write them only while no
// packet is in flight, as the block itself does not enforce it. Each packet
// goes through the steps in order, and the next packet is taken only once
// the result of the last one has been loaded. A bit-serial 64/32 restoring
// divider turns elapsed time into drained bytes, one quotient bit per cycle.
// Steps: EWMA update, divide, drain and level step, length multiply,
// wire length, queue fill and result load.
// The result sits in an output register; while it waits for out_ready_i the
// next packet is accepted and processed, and only its final load step waits
// for the output register to empty.
// Reset (rst_ni low, asynchronous) empties the virtual queue, clears the
// average, the time stamp and the level, and loads the register defaults.
`default_nettype none
module latency_hysteresis_congestion_ctl_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lhcc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [39:0]                    sojourn_i,
  input  wire logic [63:0]                    now_ns_i,
  input  wire logic [16:0]                    pkt_len_i,
  input  wire logic [2:0]                     remote_level_i,
  input  wire logic                           is_ipv6_i,
  input  wire logic [7:0]                     old_tos_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          level_o,
  output logic [7:0]                          tos_value_o,
  output logic                                rewrite_tos_o,
  output logic                                do_compress_o,
  output logic                                do_redirect_o,
  output logic [16:0]                         wire_len_o,
  output logic [23:0]                         queue_fill_o
);
  import lhcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EWMA, ST_DIV, ST_LEVEL, ST_MUL, ST_WIRE
  } state_e;

  state_e      state_q;

  // configuration
  logic [31:0] ns_per_byte_q;
  logic [23:0] queue_cap_q;
  logic [7:0]  header_saving_q;
  logic        redirect_en_q;

  // persistent state
  logic [63:0] last_time_q;
  logic [23:0] queue_q;
  lvl_t        local_q;
  logic [39:0] avg_q;
  logic [42:0] avg7_q;

  // per-packet working registers
  logic [39:0] soj_q;
  logic [16:0] len_q;
  lvl_t        remote_q;
  logic        v6_q;
  logic [7:0]  otos_q;
  logic [31:0] div_q;
  logic [63:0] dvd_q;    // dividend in, quotient out
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic [23:0] qdrain_q;
  lvl_t        lvl_q;
  logic [32:0] prod_q;

  // result registers
  logic        out_valid_q;
  lvl_t        level_q;
  logic [7:0]  tos_q;
  logic        rewrite_q;
  logic        compress_q;
  logic        redirect_q;
  logic [16:0] wire_q;
  logic [23:0] fill_q;

  logic [33:0] trial;
  logic [40:0] ewma_sum;
  lvl_t        remote_sat;
  lvl_t        local_nxt;
  logic [23:0] drained_lo;
  logic        drain_all;
  logic [16:0] wire_len;
  logic [24:0] fill_sum;
  logic [23:0] fill_sat;
  logic [7:0]  tos_new;
  logic        out_free;

  always_comb begin
    trial      = {1'b0, rem_q, dvd_q[63]} - {2'b00, div_q};
    ewma_sum   = {1'b0, avg7_q[42:3]} + {4'b0000, soj_q[39:3]};
    remote_sat = (remote_q > LVL_DROP) ? LVL_DROP : remote_q;
    local_nxt  = next_level(local_q, avg_q);
    drained_lo = dvd_q[23:0];
    drain_all  = (|dvd_q[63:24]) || (drained_lo > queue_q);
    case (lvl_q)
      LVL_COMPRESS: wire_len = (len_q > {9'd0, header_saving_q})
                               ? len_q - {9'd0, header_saving_q} : 17'd0;
      LVL_DELTA:    wire_len = {1'b0, len_q[16:1]};
      LVL_INCR:     wire_len = {2'b00, prod_q[32:DIV5_SHIFT]};
      default:      wire_len = len_q;
    endcase
    fill_sum = {1'b0, qdrain_q} + {8'd0, wire_len};
    fill_sat = (fill_sum > {1'b0, queue_cap_q}) ? queue_cap_q : fill_sum[23:0];
    tos_new  = tos_of(lvl_q);
    out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      ns_per_byte_q   <= NS_PER_BYTE_RST;
      queue_cap_q     <= QUEUE_CAP_RST;
      header_saving_q <= HEADER_SAVING_RST;
      redirect_en_q   <= 1'b0;
      last_time_q     <= '0;
      queue_q         <= '0;
      local_q         <= LVL_NORMAL;
      avg_q           <= '0;
      out_valid_q     <= 1'b0;
      cnt_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NS_PER_BYTE:   ns_per_byte_q   <= cfg_data_i;
          CFG_QUEUE_CAP:     queue_cap_q     <= cfg_data_i[23:0];
          CFG_HEADER_SAVING: header_saving_q <= cfg_data_i[7:0];
          CFG_REDIRECT_EN:   redirect_en_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      // in ST_WIRE the load step below decides the flag
      if (out_valid_q && out_ready_i && (state_q != ST_WIRE)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          avg7_q <= {avg_q, 3'b000} - {3'b000, avg_q};
          if (in_valid_i) begin
            soj_q       <= sojourn_i;
            len_q       <= pkt_len_i;
            remote_q    <= remote_level_i;
            v6_q        <= is_ipv6_i;
            otos_q      <= old_tos_i;
            div_q       <= (ns_per_byte_q == 32'd0) ? 32'd1 : ns_per_byte_q;
            dvd_q       <= now_ns_i - last_time_q;
            last_time_q <= now_ns_i;
            rem_q       <= '0;
            cnt_q       <= 6'd63;
            state_q     <= ST_EWMA;
          end
        end
        ST_EWMA: begin
          if (soj_q != 40'd0) begin
            avg_q <= (avg_q == 40'd0) ? soj_q : ewma_sum[39:0];
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // one restoring step per cycle, quotient bit shifts in at the bottom
          rem_q <= trial[33] ? {rem_q[30:0], dvd_q[63]} : trial[31:0];
          dvd_q <= {dvd_q[62:0], ~trial[33]};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) state_q <= ST_LEVEL;
        end
        ST_LEVEL: begin
          qdrain_q <= drain_all ? 24'd0 : queue_q - drained_lo;
          local_q  <= local_nxt;
          lvl_q    <= (local_nxt > remote_sat) ? local_nxt : remote_sat;
          state_q  <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= len_q * DIV5_RECIP;
          state_q <= ST_WIRE;
        end
        ST_WIRE: begin
          if (out_free) begin
            queue_q     <= fill_sat;
            out_valid_q <= 1'b1;
            level_q     <= lvl_q;
            tos_q       <= tos_new;
            rewrite_q   <= !v6_q && (otos_q != tos_new);
            compress_q  <= (lvl_q == LVL_COMPRESS);
            redirect_q  <= ((lvl_q == LVL_DELTA) || (lvl_q == LVL_INCR)) && redirect_en_q;
            wire_q      <= wire_len;
            fill_q      <= fill_sat;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign tos_value_o   = tos_q;
  assign rewrite_tos_o = rewrite_q;
  assign do_compress_o = compress_q;
  assign do_redirect_o = redirect_q;
  assign wire_len_o    = wire_q;
  assign queue_fill_o  = fill_q;

`include "latency_hysteresis_congestion_ctl_top_assert.svh"

  // partial remainder of the serial divider stays below the divisor
  `LHCC_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q))
  // the hysteresis moves at most one level per packet (3-bit difference plus one)
  `LHCC_ASSERT(a_one_step, (state_q == ST_LEVEL) |=> ((local_q - $past(local_q) + 3'd1) <= 3'd2))
  // compress flag comes only with the compress level
  `LHCC_ASSERT(a_compress_lvl, (out_valid_o && do_compress_o) |-> (level_o == LVL_COMPRESS))
  // TOS code always matches the level it goes out with
  `LHCC_ASSERT(a_tos_code, out_valid_o |-> (tos_value_o == tos_of(level_o)))
  // no input is taken while a packet is still being worked on
  `LHCC_ASSERT_ALWAYS(a_no_overlap, (!in_ready_o) || (state_q == ST_IDLE))

endmodule
`default_nettype wire
